>>> hw/rtl/bdlp_pkg.sv
// Package for the button debounce block: configuration struct, register indexes,
// event codes, emit modes and their event tables. No dependencies.
`default_nettype none
package bdlp_pkg;

  localparam int          NUM_PINS   = 6;
  localparam int          ADDR_BITS  = 4;

  localparam logic [1:0]  REG_LONG   = 2'd0;
  localparam logic [1:0]  REG_REPEAT = 2'd1;
  localparam logic [1:0]  REG_DEB    = 2'd2;
  localparam logic [1:0]  REG_MASK   = 2'd3;

  localparam logic [31:0] RST_LONG   = 32'd500;
  localparam logic [31:0] RST_REPEAT = 32'd200;
  localparam logic [3:0]  RST_DEB    = 4'd2;
  localparam logic [5:0]  RST_MASK   = 6'd63;

  typedef struct packed {
    logic [31:0] long_limit;
    logic [31:0] repeat_int;
    logic [3:0]  deb_cnt;
    logic [5:0]  al_mask;
  } cfg_t;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_SHORT   = 3'd2,
    EV_LONG    = 3'd3,
    EV_REPEAT  = 3'd4
  } ev_type_t;

  typedef enum logic [1:0] {
    MODE_LONG,
    MODE_SHORT,
    MODE_REL,
    MODE_REP
  } emit_mode_t;

  function automatic logic [1:0] mode_len(input emit_mode_t mode);
    logic [1:0] len;
    unique case (mode)
      MODE_LONG:  len = 2'd2;
      MODE_SHORT: len = 2'd3;
      MODE_REL:   len = 2'd1;
      MODE_REP:   len = 2'd1;
      default:    len = 2'd1;
    endcase
    return len;
  endfunction

  function automatic ev_type_t mode_ev(input emit_mode_t mode, input logic [1:0] step);
    ev_type_t ev;
    unique case (mode)
      MODE_LONG:  ev = (step == 2'd0) ? EV_PRESS : EV_LONG;
      MODE_SHORT: ev = (step == 2'd0) ? EV_PRESS : ((step == 2'd1) ? EV_SHORT : EV_RELEASE);
      MODE_REL:   ev = EV_RELEASE;
      MODE_REP:   ev = EV_REPEAT;
      default:    ev = EV_RELEASE;
    endcase
    return ev;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bdlp_if.sv
// Valid/ready channel interfaces for poll items and button events.
// Depends on nothing.
`default_nettype none
interface bdlp_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  raw_levels;
  logic [31:0] now_tick;

  modport source (output valid, raw_levels, now_tick, input ready);
  modport sink   (input valid, raw_levels, now_tick, output ready);
endinterface

interface bdlp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  button_index;
  logic [2:0]  event_type;
  logic [31:0] sequence_number;
  logic        last_of_poll;

  modport source (output valid, button_index, event_type, sequence_number, last_of_poll,
                  input ready);
  modport sink   (input valid, button_index, event_type, sequence_number, last_of_poll,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bdlp_cfg_regs.sv
// APB-style configuration registers for the button debounce block.
// Depends on bdlp_pkg.
`default_nettype none
module bdlp_cfg_regs
  import bdlp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  cfg_t       cfg_r;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_limit <= RST_LONG;
      cfg_r.repeat_int <= RST_REPEAT;
      cfg_r.deb_cnt    <= RST_DEB;
      cfg_r.al_mask    <= RST_MASK;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LONG:   cfg_r.long_limit <= pwdata;
        REG_REPEAT: cfg_r.repeat_int <= pwdata;
        REG_DEB:    cfg_r.deb_cnt    <= pwdata[3:0];
        REG_MASK:   cfg_r.al_mask    <= pwdata[5:0];
        default:    cfg_r            <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LONG:   prdata = cfg_r.long_limit;
      REG_REPEAT: prdata = cfg_r.repeat_int;
      REG_DEB:    prdata = {28'd0, cfg_r.deb_cnt};
      REG_MASK:   prdata = {26'd0, cfg_r.al_mask};
      default:    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/bdlp_elapsed_unit.sv
// Shared elapsed-time unit: wrapping subtract of a time stamp from the poll
// tick and unsigned compare against a 32-bit limit. No dependencies.
`default_nettype none
module bdlp_elapsed_unit #(
  parameter int TIME_BITS = 32
) (
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic [TIME_BITS-1:0] stamp,
  input  wire logic [31:0]          limit,
  output logic                      reached
);

  logic [TIME_BITS-1:0] elapsed;

  assign elapsed = now - stamp;
  assign reached = 32'(elapsed) >= limit;

endmodule
`default_nettype wire

>>> hw/rtl/button_debounce_long_press_repeat.sv
// Button debounce with long press and auto-repeat, top level with the sequencer.
// Depends on bdlp_pkg, bdlp_if, bdlp_cfg_regs and bdlp_elapsed_unit.
//
// One poll transaction is taken while the block is idle; the sequencer then visits the
// buttons in index order. Each button gets a debounce step, plus a hold-time compare
// when held and a repeat compare once long has been sent, all on a single shared
// subtract-and-compare unit, plus an emit step for each event. Events leave through a
// one-deep pending stage and an output register, so the last event of a poll is
// flagged once the scan is done; output backpressure stalls the emit and flush steps.
`default_nettype none
module button_debounce_long_press_repeat
  import bdlp_pkg::*;
#(
  parameter int BUTTON_COUNT = 6,
  parameter int TIME_BITS    = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bdlp_in_if.sink                   in_ch,
  bdlp_out_if.source                out_ch,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);

  localparam int BIDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam logic [BIDX_W-1:0] LAST_IDX = BIDX_W'(BUTTON_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEB,
    S_HELD,
    S_SINCE,
    S_EMIT,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [2:0]  btn;
    ev_type_t    ev;
    logic [31:0] seq;
  } event_t;

  cfg_t cfg;

  state_t               state_r;
  logic [BIDX_W-1:0]    idx_r;
  logic [5:0]           levels_r;
  logic [TIME_BITS-1:0] now_r;
  logic [31:0]          seq_r;
  emit_mode_t           mode_r;
  logic [1:0]           step_r;

  logic                 raw_seen_r    [BUTTON_COUNT];
  logic                 stable_r      [BUTTON_COUNT];
  logic [3:0]           polls_r       [BUTTON_COUNT];
  logic                 long_sent_r   [BUTTON_COUNT];
  logic [TIME_BITS-1:0] press_start_r [BUTTON_COUNT];
  logic [TIME_BITS-1:0] last_rep_r    [BUTTON_COUNT];

  logic                 pend_valid_r;
  event_t               pend_r;
  logic                 out_valid_r;
  event_t               out_r;
  logic                 out_last_r;

  logic [5:0]           lvl_sh;
  logic [5:0]           msk_sh;
  logic                 raw_cur;
  logic                 seen_nxt;
  logic [3:0]           polls_nxt;
  logic                 sel_since;
  logic [TIME_BITS-1:0] stamp;
  logic [31:0]          limit;
  logic                 reached;
  logic                 out_free;
  logic                 can_push;
  logic                 out_load;
  event_t               new_ev;
  state_t               adv_state;
  logic [BIDX_W-1:0]    adv_idx;

  bdlp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign sel_since = (state_r == S_SINCE);
  assign stamp     = sel_since ? last_rep_r[idx_r] : press_start_r[idx_r];
  assign limit     = sel_since ? cfg.repeat_int : cfg.long_limit;

  bdlp_elapsed_unit #(.TIME_BITS(TIME_BITS)) u_elapsed (
    .now     (now_r),
    .stamp   (stamp),
    .limit   (limit),
    .reached (reached)
  );

  always_comb begin
    lvl_sh  = levels_r >> idx_r;
    msk_sh  = cfg.al_mask >> idx_r;
    raw_cur = lvl_sh[0] ^ msk_sh[0];
    if (raw_cur == raw_seen_r[idx_r]) begin
      seen_nxt  = raw_seen_r[idx_r];
      polls_nxt = (polls_r[idx_r] < cfg.deb_cnt) ? polls_r[idx_r] + 4'd1 : polls_r[idx_r];
    end else begin
      seen_nxt  = raw_cur;
      polls_nxt = 4'd1;
    end
    adv_state = (idx_r == LAST_IDX) ? S_FLUSH : S_DEB;
    adv_idx   = (idx_r == LAST_IDX) ? idx_r : idx_r + BIDX_W'(1);
  end

  assign out_free   = !out_valid_r || out_ch.ready;
  assign can_push   = !pend_valid_r || out_free;
  assign out_load   = ((state_r == S_EMIT) && can_push && pend_valid_r) ||
                      ((state_r == S_FLUSH) && pend_valid_r && out_free);
  assign new_ev.btn = 3'(idx_r);
  assign new_ev.ev  = mode_ev(mode_r, step_r);
  assign new_ev.seq = seq_r;

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.button_index    = out_r.btn;
  assign out_ch.event_type      = out_r.ev;
  assign out_ch.sequence_number = out_r.seq;
  assign out_ch.last_of_poll    = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      seq_r        <= 32'd0;
      mode_r       <= MODE_REL;
      step_r       <= 2'd0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        raw_seen_r[i]    <= 1'b0;
        stable_r[i]      <= 1'b0;
        polls_r[i]       <= RST_DEB;
        long_sent_r[i]   <= 1'b0;
        press_start_r[i] <= '0;
        last_rep_r[i]    <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            levels_r <= in_ch.raw_levels;
            now_r    <= in_ch.now_tick[TIME_BITS-1:0];
            idx_r    <= '0;
            state_r  <= S_DEB;
          end
        end
        S_DEB: begin
          raw_seen_r[idx_r] <= seen_nxt;
          polls_r[idx_r]    <= polls_nxt;
          if (polls_nxt < cfg.deb_cnt) begin
            state_r <= adv_state;
            idx_r   <= adv_idx;
          end else if (stable_r[idx_r] == seen_nxt) begin
            if (seen_nxt) begin
              state_r <= S_HELD;
            end else begin
              state_r <= adv_state;
              idx_r   <= adv_idx;
            end
          end else begin
            stable_r[idx_r] <= seen_nxt;
            step_r          <= 2'd0;
            if (seen_nxt) begin
              press_start_r[idx_r] <= now_r;
              long_sent_r[idx_r]   <= 1'b0;
              state_r              <= adv_state;
              idx_r                <= adv_idx;
            end else if (long_sent_r[idx_r]) begin
              mode_r  <= MODE_REL;
              state_r <= S_EMIT;
            end else begin
              seq_r   <= seq_r + 32'd1;
              mode_r  <= MODE_SHORT;
              state_r <= S_EMIT;
            end
          end
        end
        S_HELD: begin
          step_r <= 2'd0;
          if (!long_sent_r[idx_r] && reached) begin
            long_sent_r[idx_r] <= 1'b1;
            last_rep_r[idx_r]  <= now_r;
            seq_r              <= seq_r + 32'd1;
            mode_r             <= MODE_LONG;
            state_r            <= S_EMIT;
          end else if (long_sent_r[idx_r]) begin
            state_r <= S_SINCE;
          end else begin
            state_r <= adv_state;
            idx_r   <= adv_idx;
          end
        end
        S_SINCE: begin
          step_r <= 2'd0;
          if (reached) begin
            last_rep_r[idx_r] <= now_r;
            mode_r            <= MODE_REP;
            state_r           <= S_EMIT;
          end else begin
            state_r <= adv_state;
            idx_r   <= adv_idx;
          end
        end
        S_EMIT: begin
          if (can_push) begin
            if (pend_valid_r) begin
              out_r      <= pend_r;
              out_last_r <= 1'b0;
            end
            pend_r       <= new_ev;
            pend_valid_r <= 1'b1;
            if (step_r == mode_len(mode_r) - 2'd1) begin
              state_r <= adv_state;
              idx_r   <= adv_idx;
            end else begin
              step_r <= step_r + 2'd1;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_r        <= pend_r;
            out_last_r   <= 1'b1;
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !pend_valid_r)
    else $error("pending event left over while idle");

  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (seq_r == $past(seq_r)) || (seq_r == $past(seq_r) + 32'd1))
    else $error("sequence counter moved by more than one");

  a_emit_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (step_r < mode_len(mode_r)))
    else $error("emit step beyond event group");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=>
      (out_valid_r && $stable(out_r) && $stable(out_last_r)))
    else $error("output event changed while waiting");

endmodule
`default_nettype wire
